FILE: sv/fiv_pkg.sv
package fiv_pkg;

  localparam logic [31:0] CrcPoly         = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit         = 32'hFFFF_FFFF;
  localparam logic [31:0] StackMask       = 32'h2FFE_0000;
  localparam logic [31:0] StackMatch      = 32'h2000_0000;
  localparam logic [31:0] EntryMask       = 32'hFF00_0000;
  localparam logic [31:0] EntryMatch      = 32'h0800_0000;
  localparam logic [31:0] MaxImageBytes   = 32'd1048576;
  localparam logic [31:0] RegionBaseReset = 32'h0800_5000;
  localparam logic [20:0] RegionSizeReset = 21'h04_0000;

  typedef enum logic {
    FuncData  = 1'b0,
    FuncStart = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    VerdictOk          = 3'd0,
    VerdictBadLength   = 3'd1,
    VerdictCrcMismatch = 3'd2,
    VerdictBadStack    = 3'd3,
    VerdictEntryClass  = 3'd4,
    VerdictEntryRange  = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    CfgExpectedCrc = 2'd0,
    CfgImageLength = 2'd1,
    CfgRegionBase  = 2'd2,
    CfgRegionSize  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] computed_crc;
    logic [31:0] stack_word;
    logic [31:0] entry_word;
  } result_t;

  typedef struct packed {
    logic [31:0] expected_crc;
    logic [20:0] image_length;
    logic [31:0] region_base;
    logic [20:0] region_size;
  } cfg_t;

endpackage

FILE: sv/fiv_if.sv
interface fiv_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface fiv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [31:0] computed_crc;
  logic [31:0] stack_word;
  logic [31:0] entry_word;

  modport source (output valid, output verdict, output computed_crc, output stack_word,
                  output entry_word, input ready);
  modport sink (input valid, input verdict, input computed_crc, input stack_word,
                input entry_word, output ready);
endinterface

FILE: sv/fiv_in_reg.sv
module fiv_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  fiv_pkg::item_t  item_i,
  input  logic            take_i,
  output logic            valid_o,
  output fiv_pkg::item_t  item_o
);
  import fiv_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: sv/fiv_core.sv
module fiv_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fiv_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  input  fiv_pkg::item_t    item_i,
  input  logic              out_free_i,
  output logic              take_o,
  output logic              res_valid_o,
  output fiv_pkg::result_t  res_o
);
  import fiv_pkg::*;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CrcPoly : 32'd0);
    end
    return r;
  endfunction

  logic [31:0]     crc_q, crc_d, crc_n;
  logic [20:0]     seen_q, seen_d, seen_n;
  logic [7:0][7:0] vec_q, vec_d, vec_n;
  logic            active_q, active_d;
  logic            bad_len;
  logic [32:0]     region_end;
  logic [31:0]     crc_out, stack_w, entry_w;

  assign take_o = valid_i && out_free_i;

  assign bad_len = (cfg_i.image_length == 21'd0) ||
                   (cfg_i.image_length > cfg_i.region_size) ||
                   ({11'd0, cfg_i.image_length} > MaxImageBytes);
  assign region_end = {1'b0, cfg_i.region_base} + {12'd0, cfg_i.region_size};

  always_comb begin
    crc_n = crc_byte(crc_q, item_i.data_byte);
    seen_n = seen_q + 21'd1;
    vec_n = vec_q;
    if (seen_q[20:3] == 18'd0) begin
      vec_n[seen_q[2:0]] = item_i.data_byte;
    end
    crc_out = ~crc_n;
    stack_w = vec_n[3:0];
    entry_w = vec_n[7:4];
  end

  always_comb begin
    crc_d       = crc_q;
    seen_d      = seen_q;
    vec_d       = vec_q;
    active_d    = active_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (take_o) begin
      unique case (item_i.func)
        FuncStart: begin
          crc_d    = CrcInit;
          seen_d   = 21'd0;
          vec_d    = '0;
          active_d = !bad_len;
          if (bad_len) begin
            res_valid_o   = 1'b1;
            res_o.verdict = VerdictBadLength;
          end
        end
        FuncData: begin
          if (active_q) begin
            crc_d  = crc_n;
            seen_d = seen_n;
            vec_d  = vec_n;
            if (seen_n >= cfg_i.image_length) begin
              active_d           = 1'b0;
              res_valid_o        = 1'b1;
              res_o.computed_crc = crc_out;
              res_o.stack_word   = stack_w;
              res_o.entry_word   = entry_w;
              priority if (crc_out != cfg_i.expected_crc) begin
                res_o.verdict = VerdictCrcMismatch;
              end else if ((stack_w & StackMask) != StackMatch) begin
                res_o.verdict = VerdictBadStack;
              end else if ((entry_w & EntryMask) != EntryMatch) begin
                res_o.verdict = VerdictEntryClass;
              end else if (entry_w < cfg_i.region_base ||
                           {1'b0, entry_w} >= region_end) begin
                res_o.verdict = VerdictEntryRange;
              end else begin
                res_o.verdict = VerdictOk;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CrcInit;
      seen_q   <= 21'd0;
      vec_q    <= '0;
      active_q <= 1'b0;
    end else begin
      crc_q    <= crc_d;
      seen_q   <= seen_d;
      vec_q    <= vec_d;
      active_q <= active_d;
    end
  end

endmodule

FILE: sv/fiv_out_reg.sv
module fiv_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  fiv_pkg::result_t  res_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output fiv_pkg::result_t  res_o
);
  import fiv_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: sv/firmware_image_verifier_unit.sv
// streaming firmware image check: a start word arms a check (or answers at once with
// a bad-length verdict), then each data word feeds one image byte into a reflected
// crc-32 and captures the stack and entry vectors from the first eight bytes; the byte
// that reaches the configured length yields one verdict word. one word is taken every
// cycle, start or data, as long as the output side keeps accepting; a verdict that waits
// at the output holds the next word in the input register and stalls the input until it
// is taken. the crc byte update and the verdict checks sit between the input register
// and the result register, so a verdict appears the cycle after its byte is taken. write
// the configuration registers only while no check is in flight.
module firmware_image_verifier_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  fiv_in_if.sink       in_i,
  fiv_out_if.source    out_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);
  import fiv_pkg::*;

  cfg_t    cfg_q;
  item_t   in_item, s1_item;
  logic    s1_valid, take, out_free, res_valid;
  result_t res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_crc <= 32'd0;
      cfg_q.image_length <= 21'd0;
      cfg_q.region_base  <= RegionBaseReset;
      cfg_q.region_size  <= RegionSizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgExpectedCrc: cfg_q.expected_crc <= cfg_wdata_i;
        CfgImageLength: cfg_q.image_length <= cfg_wdata_i[20:0];
        CfgRegionBase:  cfg_q.region_base  <= cfg_wdata_i;
        CfgRegionSize:  cfg_q.region_size  <= cfg_wdata_i[20:0];
        default: ;
      endcase
    end
  end

  assign in_item.func      = func_e'(in_i.func);
  assign in_item.data_byte = in_i.data_byte;

  fiv_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .take_i  (take),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  fiv_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (s1_valid),
    .item_i      (s1_item),
    .out_free_i  (out_free),
    .take_o      (take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fiv_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_res)
  );

  assign out_o.verdict      = out_res.verdict;
  assign out_o.computed_crc = out_res.computed_crc;
  assign out_o.stack_word   = out_res.stack_word;
  assign out_o.entry_word   = out_res.entry_word;

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_o.valid || out_o.ready))
    else $error("verdict loaded over a pending one");

  a_bad_length_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.verdict == VerdictBadLength) |->
      (out_o.computed_crc == 32'd0 && out_o.stack_word == 32'd0 &&
       out_o.entry_word == 32'd0))
    else $error("bad-length verdict with nonzero fields");

  a_ok_matches_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.verdict == VerdictOk) |->
      (out_o.computed_crc == cfg_q.expected_crc))
    else $error("ok verdict without crc match");

endmodule

FILE: sim/firmware_image_verifier_checker.sv
module firmware_image_verifier_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  fiv_in_if           in_i,
  fiv_out_if          out_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output int          mismatches_o,
  output int          pending_o,
  output logic        armed_o,
  output logic [31:0] last_crc_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fiv_pkg::*;

  cfg_t        cfg;
  logic [31:0] crc_acc;
  logic [20:0] bytes_seen;
  logic [63:0] vector_bytes;
  logic        armed;
  logic [31:0] last_crc;
  result_t     verdict_q[$];
  int          errors;

  function automatic logic [31:0] crc_feed(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    int          k;
    r = c ^ {24'd0, b};
    for (k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  function automatic void restart_check();
    crc_acc      = CrcInit;
    bytes_seen   = '0;
    vector_bytes = '0;
    armed        = 1'b0;
  endfunction

  // returns 1 when the word yields a verdict
  function automatic bit predict_word(item_t w, output result_t res);
    logic [32:0] region_end;
    res = '0;
    if (w.func == FuncStart) begin
      restart_check();
      if (cfg.image_length == '0 || cfg.image_length > cfg.region_size ||
          {11'd0, cfg.image_length} > MaxImageBytes) begin
        res.verdict = VerdictBadLength;
        return 1'b1;
      end
      armed = 1'b1;
      return 1'b0;
    end
    if (!armed) return 1'b0;
    crc_acc = crc_feed(crc_acc, w.data_byte);
    if (bytes_seen < 21'd8) vector_bytes[8*bytes_seen[2:0] +: 8] = w.data_byte;
    bytes_seen = bytes_seen + 21'd1;
    if (bytes_seen < cfg.image_length) return 1'b0;
    armed            = 1'b0;
    res.computed_crc = ~crc_acc;
    res.stack_word   = vector_bytes[31:0];
    res.entry_word   = vector_bytes[63:32];
    region_end       = {1'b0, cfg.region_base} + {12'd0, cfg.region_size};
    if (res.computed_crc != cfg.expected_crc) begin
      res.verdict = VerdictCrcMismatch;
    end else if ((res.stack_word & StackMask) != StackMatch) begin
      res.verdict = VerdictBadStack;
    end else if ((res.entry_word & EntryMask) != EntryMatch) begin
      res.verdict = VerdictEntryClass;
    end else if (res.entry_word < cfg.region_base || {1'b0, res.entry_word} >= region_end) begin
      res.verdict = VerdictEntryRange;
    end else begin
      res.verdict = VerdictOk;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
    errors++;
    if (errors <= 100) $display("[%0t] %s: got %h, want %h", $realtime, what, seen, wanted);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_words
    item_t   word_in;
    result_t want;
    if (!rst_ni) begin
      cfg.expected_crc = '0;
      cfg.image_length = '0;
      cfg.region_base  = RegionBaseReset;
      cfg.region_size  = RegionSizeReset;
      restart_check();
      verdict_q.delete();
      errors   = 0;
      last_crc = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgExpectedCrc: cfg.expected_crc = cfg_wdata_i;
          CfgImageLength: cfg.image_length = cfg_wdata_i[20:0];
          CfgRegionBase:  cfg.region_base  = cfg_wdata_i;
          CfgRegionSize:  cfg.region_size  = cfg_wdata_i[20:0];
          default: ;
        endcase
      end
      if (out_i.valid === 1'b1 && out_i.ready === 1'b1) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict word with none expected", {29'd0, out_i.verdict}, '0);
        end else begin
          want = verdict_q.pop_front();
          if (out_i.verdict !== want.verdict)
            report_mismatch("verdict", {29'd0, out_i.verdict}, {29'd0, want.verdict});
          if (out_i.computed_crc !== want.computed_crc)
            report_mismatch("computed_crc", out_i.computed_crc, want.computed_crc);
          if (out_i.stack_word !== want.stack_word)
            report_mismatch("stack_word", out_i.stack_word, want.stack_word);
          if (out_i.entry_word !== want.entry_word)
            report_mismatch("entry_word", out_i.entry_word, want.entry_word);
        end
      end
      if (in_i.valid === 1'b1 && in_i.ready === 1'b1) begin
        word_in.func      = func_e'(in_i.func);
        word_in.data_byte = in_i.data_byte;
        if (predict_word(word_in, want)) begin
          verdict_q.push_back(want);
          last_crc = want.computed_crc;
        end
      end
    end
    mismatches_o <= errors;
    pending_o    <= verdict_q.size();
    armed_o      <= armed;
    last_crc_o   <= last_crc;
  end

endmodule

FILE: sim/firmware_image_verifier_unit_tb.sv
module firmware_image_verifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fiv_pkg::*;

  localparam int WordTarget   = 1700;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 6;
  localparam logic [20:0] LenMax = 21'h10_0000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  int          mismatches;
  int          verdicts_due;
  logic        check_armed;
  logic [31:0] last_crc;
  int          cycles = 0;
  int          words_sent;
  bit          send_quiet;
  bit          take_quiet;
  logic [31:0] base_now;
  logic [20:0] size_now;
  logic [7:0]  image_q[$];

  fiv_in_if  in_if();
  fiv_out_if out_if();

  firmware_image_verifier_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  firmware_image_verifier_checker image_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .pending_o    (verdicts_due),
    .armed_o      (check_armed),
    .last_crc_o   (last_crc)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = take_quiet ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid === 1'b1 && out_if.ready));
    end
  end

  task automatic send_word(func_e f, logic [7:0] b);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= f;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
  endtask

  task automatic load_config(logic [31:0] crc, logic [20:0] len, logic [31:0] base,
                             logic [20:0] size);
    write_reg(CfgExpectedCrc, crc);
    write_reg(CfgImageLength, {11'd0, len});
    write_reg(CfgRegionBase, base);
    write_reg(CfgRegionSize, {11'd0, size});
    cfg_we   <= 1'b0;
    base_now = base;
    size_now = size;
  endtask

  // finish any armed check, then drain verdicts and let the pipeline empty
  task automatic settle();
    forever begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      if (!check_armed) break;
      send_word(FuncData, 8'($urandom));
    end
    while (verdicts_due != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void build_image(int len, bit shaped);
    logic [31:0] sp;
    logic [31:0] pc;
    int          k;
    image_q.delete();
    repeat (len) image_q.push_back(8'($urandom));
    if (!shaped) return;
    sp = ($urandom & ~StackMask) | StackMatch;
    if ($urandom_range(0, 5) == 0) sp = sp ^ (32'h1 << $urandom_range(17, 29));
    case ($urandom_range(0, 6))
      0: pc = base_now;
      1: pc = base_now + {11'd0, size_now} - 32'd1;
      2: pc = base_now + {11'd0, size_now};
      3: pc = base_now - 32'd1;
      4: pc = {8'h08, 24'($urandom)};
      5: pc = $urandom;
      default: pc = base_now + $urandom_range(0, {11'd0, size_now});
    endcase
    for (k = 0; k < 8 && k < len; k++) begin
      image_q[k] = (k < 4) ? sp[8*k +: 8] : pc[8*(k-4) +: 8];
    end
  endfunction

  task automatic play_image(bit restart_noise);
    int cut;
    cut = restart_noise ? $urandom_range(0, image_q.size()) : -1;
    send_word(FuncStart, 8'($urandom));
    words_sent++;
    foreach (image_q[i]) begin
      if (i == cut) send_word(FuncStart, 8'($urandom));
      send_word(FuncData, image_q[i]);
      words_sent++;
    end
    // bytes past the end are ignored
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_word(FuncData, 8'($urandom));
    end
  endtask

  initial begin
    logic [31:0] base;
    logic [20:0] size;
    logic [20:0] len;
    bit          len_ok;
    int          n;
    int          j;
    in_if.valid     = 1'b0;
    in_if.func      = FuncData;
    in_if.data_byte = 8'h00;
    cfg_we          = 1'b0;
    cfg_idx         = CfgExpectedCrc;
    cfg_wdata       = '0;
    send_quiet      = 1'b0;
    take_quiet      = 1'b0;
    words_sent      = 0;
    base_now        = RegionBaseReset;
    size_now        = RegionSizeReset;
    rst_ni          = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config has zero length, then a stray byte with no check armed
    send_word(FuncStart, 8'h00);
    send_word(FuncData, 8'hFF);
    settle();

    load_config(32'h0, 21'd8, 32'h0800_0000, 21'h100);
    image_q = '{8'h00, 8'h10, 8'h00, 8'h20, 8'hFF, 8'h00, 8'h00, 8'h08};
    play_image(1'b0);
    send_word(FuncData, 8'h5A);
    settle();
    load_config(last_crc, 21'd8, 32'h0800_0000, 21'h100);
    play_image(1'b0);
    settle();

    // short image, region end past 32 bits
    load_config(32'hFFFF_FFFF, 21'd3, 32'hFFFF_FFFF, LenMax);
    image_q = '{8'h00, 8'hFF, 8'hA5};
    play_image(1'b0);
    settle();

    load_config(32'h0, LenMax, RegionBaseReset, LenMax - 21'd1);
    send_word(FuncStart, 8'hFF);
    settle();

    while (words_sent < WordTarget) begin
      send_quiet = ($urandom_range(0, 3) == 0);
      take_quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: size = LenMax;
        1: size = 21'd1;
        2: size = 21'd0;
        default: size = 21'($urandom_range(8, 4096));
      endcase
      case ($urandom_range(0, 11))
        0: len = 21'd0;
        1: len = (size == LenMax) ? 21'd0 : size + 21'd1;
        2: len = (size == LenMax) ? 21'd0 : LenMax;
        3: len = (size < 21'd21) ? size : 21'($urandom_range(21, (size > 300) ? 300 : size));
        default: len = 21'($urandom_range(1, 20));
      endcase
      len_ok = (len != 0) && (len <= size);
      case ($urandom_range(0, 7))
        0: base = 32'h0;
        1: base = 32'hFFFF_FFFF;
        2: base = $urandom;
        default: base = 32'h0800_0000 + $urandom_range(0, 32'h00F0_0000);
      endcase
      load_config($urandom, len, base, size);
      n = $urandom_range(1, 3);
      for (j = 0; j < n; j++) begin
        build_image(len_ok ? int'(len) : $urandom_range(0, 3), $urandom_range(0, 3) != 0);
        play_image(len_ok && j < n - 1 && $urandom_range(0, 4) == 0);
      end
      settle();
      // same image again with its own crc expected
      if (len_ok && $urandom_range(0, 1) == 1) begin
        load_config(last_crc, len, base, size);
        play_image(1'b0);
        settle();
      end
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/fiv_pkg.sv
sv/fiv_if.sv
sv/fiv_in_reg.sv
sv/fiv_core.sv
sv/fiv_out_reg.sv
sv/firmware_image_verifier_unit.sv
sim/firmware_image_verifier_checker.sv
sim/firmware_image_verifier_unit_tb.sv
